### src/ldmc_pkg.sv
// ============================================================================
// ldmc_pkg - lamp dimmer mode controller package
// Shared types, field widths and reset values of the lamp dimmer controller.
// ============================================================================
package ldmc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 12;
    localparam int DUTY_W     = 14;
    localparam int MODE_W     = 2;
    localparam int STEP_W     = 10;
    localparam int SETPOINT_W = 12;
    localparam int DEADBAND_W = 11;
    localparam int RADIO_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    // Parameter defaults
    localparam int WINDOW_LEN_DEF = 10;
    localparam int MAX_DUTY_DEF   = 9999;
    localparam int SAMPLE_MAX_DEF = 4095;

    // Register reset values
    localparam logic [STEP_W-1:0]     STEP_SIZE_RST = 10'd10;
    localparam logic [SETPOINT_W-1:0] SETPOINT_RST  = 12'd2000;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RST  = 11'd100;

    // Radio command byte that selects full on ('c')
    localparam logic [RADIO_W-1:0] RADIO_ON_CODE = 8'h63;

    // Operating modes, coded as on the result channel
    typedef enum logic [MODE_W-1:0] {
        MODE_SENSOR = 2'd0,
        MODE_POT    = 2'd1,
        MODE_ON     = 2'd2,
        MODE_OFF    = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_SIZE = 2'd0,
        CFG_SETPOINT  = 2'd1,
        CFG_DEADBAND  = 2'd2
    } cfg_index_t;

    // Where the duty of an item comes from
    typedef enum logic [1:0] {
        SRC_DIRECT = 2'd0,  // value known at accept
        SRC_POT    = 2'd1,  // mapped from the knob window total
        SRC_HOLD   = 2'd2   // repeat the previous duty
    } duty_src_t;

endpackage

### src/lamp_dimmer_mode_controller_top.sv
// ============================================================================
// lamp_dimmer_mode_controller_top - lamp dimmer mode controller
// Picks the lamp mode from buttons and radio and computes the PWM duty.
// ============================================================================
//
// Usage:
//   s_* stream: one control tick per transfer, fields in s_tdata.
//   m_* stream: one result (duty, active mode) per input transfer, in order.
//   cfg_*: register write channel, always ready; write only while idle.
// Throughput: one tick per cycle while not stalled. Mode, sensor level and
//   knob window are updated at the input transfer. Every item then runs
//   through three pipeline stages, where the pot mapping (window average,
//   scale, divide by SAMPLE_MAX) uses one constant multiplier each, and
//   its duty is resolved in the result register that drives m_tvalid.
// Stall: the whole pipeline advances only while the result register is
//   empty or being taken, so s_tready follows m_tready when full.
// Reset: aresetn low clears the pipeline, sets mode off, level and duty to
//   zero, clears the knob window and loads the register defaults. No
//   clearing pass is needed; the block is ready the cycle after reset.
//
module lamp_dimmer_mode_controller_top #(
    parameter int WINDOW_LEN = ldmc_pkg::WINDOW_LEN_DEF,
    parameter int MAX_DUTY   = ldmc_pkg::MAX_DUTY_DEF,
    parameter int SAMPLE_MAX = ldmc_pkg::SAMPLE_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] press_sensor_mode, [1] press_pot_mode, [2] press_full_on,
    // [3] press_full_off, [15:4] light_sample, [27:16] knob_sample,
    // [28] radio_valid, [36:29] radio_first_byte, [39:37] zero
    input  logic [ldmc_pkg::S_DATA_W-1:0]   s_tdata,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [13:0] duty, [15:14] active_mode
    output logic [ldmc_pkg::M_DATA_W-1:0]   m_tdata,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ldmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldmc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int SAMPLE_W = ldmc_pkg::SAMPLE_W;
    localparam int DUTY_W   = ldmc_pkg::DUTY_W;
    localparam int PTR_W    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOT_W    = $clog2(WINDOW_LEN * ((1 << SAMPLE_W) - 1) + 1);
    localparam int BAND_W   = SAMPLE_W + 1;
    localparam int LVL_W    = DUTY_W + 1;
    localparam int AVG_W    = SAMPLE_W;
    localparam int PROD_W   = AVG_W + DUTY_W;

    // Exact floor division by reciprocal: x < 2**N, S = N + clog2(D),
    // M = ceil(2**S / D) gives floor(x / D) = (x * M) >> S.
    localparam int S1 = TOT_W + $clog2(WINDOW_LEN);
    localparam logic [63:0] RECIP1 =
        ((64'd1 << S1) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [TOT_W:0] M1 = RECIP1[TOT_W:0];
    localparam int S2 = PROD_W + $clog2(SAMPLE_MAX);
    localparam logic [63:0] RECIP2 =
        ((64'd1 << S2) + 64'(SAMPLE_MAX) - 64'd1) / 64'(SAMPLE_MAX);
    localparam logic [PROD_W:0] M2 = RECIP2[PROD_W:0];
    localparam int Q_W = 2 * PROD_W + 1 - S2;

    localparam logic [DUTY_W-1:0] MAX_DUTY_V  = DUTY_W'(MAX_DUTY);
    localparam logic [PTR_W-1:0]  PTR_LAST    = PTR_W'(WINDOW_LEN - 1);

    // ------------------------------------------------------------------
    // Input field unpacking
    // ------------------------------------------------------------------
    logic                             in_sensor_btn;
    logic                             in_pot_btn;
    logic                             in_on_btn;
    logic                             in_off_btn;
    logic [SAMPLE_W-1:0]              in_light;
    logic [SAMPLE_W-1:0]              in_knob;
    logic                             in_radio_valid;
    logic [ldmc_pkg::RADIO_W-1:0]     in_radio_byte;

    assign in_sensor_btn  = s_tdata[0];
    assign in_pot_btn     = s_tdata[1];
    assign in_on_btn      = s_tdata[2];
    assign in_off_btn     = s_tdata[3];
    assign in_light       = s_tdata[15:4];
    assign in_knob        = s_tdata[27:16];
    assign in_radio_valid = s_tdata[28];
    assign in_radio_byte  = s_tdata[36:29];

    // ------------------------------------------------------------------
    // Handshake and pipeline enable
    // ------------------------------------------------------------------
    logic pipe_en;
    logic in_xfer;
    logic m_valid_reg;

    assign pipe_en   = !m_valid_reg || m_tready;
    assign s_tready  = pipe_en;
    assign in_xfer   = s_tvalid && pipe_en;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ldmc_pkg::STEP_W-1:0]     step_size_reg;
    logic [ldmc_pkg::SETPOINT_W-1:0] setpoint_reg;
    logic [ldmc_pkg::DEADBAND_W-1:0] deadband_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= ldmc_pkg::STEP_SIZE_RST;
            setpoint_reg  <= ldmc_pkg::SETPOINT_RST;
            deadband_reg  <= ldmc_pkg::DEADBAND_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                ldmc_pkg::CFG_STEP_SIZE: step_size_reg <= cfg_data[ldmc_pkg::STEP_W-1:0];
                ldmc_pkg::CFG_SETPOINT:  setpoint_reg  <= cfg_data;
                ldmc_pkg::CFG_DEADBAND:  deadband_reg  <= cfg_data[ldmc_pkg::DEADBAND_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tick state
    // ------------------------------------------------------------------
    ldmc_pkg::mode_t     mode_reg, mode_next;
    logic [DUTY_W-1:0]   level_reg, level_next;
    logic [SAMPLE_W-1:0] knob_ring_reg [WINDOW_LEN];
    logic [PTR_W-1:0]    ring_ptr_reg, ring_ptr_next;
    logic [TOT_W-1:0]    ring_total_reg, ring_total_next;
    logic                ring_wr;

    ldmc_pkg::duty_src_t src_next;
    logic [DUTY_W-1:0]   dval_next;

    logic [LVL_W-1:0]    level_up;
    logic [BAND_W-1:0]   light_plus_band;
    logic [BAND_W-1:0]   set_plus_band;
    logic                below_band;
    logic                above_band;

    // Band checks without signed edges: light < sp - db and light > sp + db
    assign light_plus_band = BAND_W'(in_light) + BAND_W'(deadband_reg);
    assign set_plus_band   = BAND_W'(setpoint_reg) + BAND_W'(deadband_reg);
    assign below_band      = light_plus_band < BAND_W'(setpoint_reg);
    assign above_band      = BAND_W'(in_light) > set_plus_band;
    assign level_up        = LVL_W'(level_reg) + LVL_W'(step_size_reg);

    // Mode selection and per-mode update for the item being accepted
    always_comb begin
        mode_next       = mode_reg;
        level_next      = level_reg;
        ring_ptr_next   = ring_ptr_reg;
        ring_total_next = ring_total_reg;
        ring_wr         = 1'b0;
        src_next        = ldmc_pkg::SRC_DIRECT;
        dval_next       = '0;

        if (in_radio_valid && in_radio_byte == ldmc_pkg::RADIO_ON_CODE) begin
            mode_next = ldmc_pkg::MODE_ON;
        end
        priority if (in_sensor_btn) begin
            mode_next = ldmc_pkg::MODE_SENSOR;
        end else if (in_pot_btn) begin
            mode_next = ldmc_pkg::MODE_POT;
        end else if (in_on_btn) begin
            mode_next = ldmc_pkg::MODE_ON;
        end else if (in_off_btn) begin
            mode_next = ldmc_pkg::MODE_OFF;
        end else begin
            // no button: keep radio or previous mode
        end

        unique case (mode_next)
            ldmc_pkg::MODE_SENSOR: begin
                priority if (below_band) begin
                    level_next = (level_up > LVL_W'(MAX_DUTY)) ? MAX_DUTY_V
                                                               : level_up[DUTY_W-1:0];
                    dval_next  = level_next;
                end else if (above_band) begin
                    level_next = (level_reg > DUTY_W'(step_size_reg))
                               ? level_reg - DUTY_W'(step_size_reg) : '0;
                    dval_next  = level_next;
                end else begin
                    // inside the deadband the previous duty stays
                    src_next = ldmc_pkg::SRC_HOLD;
                end
            end
            ldmc_pkg::MODE_POT: begin
                ring_wr         = 1'b1;
                ring_total_next = ring_total_reg - TOT_W'(knob_ring_reg[ring_ptr_reg])
                                + TOT_W'(in_knob);
                ring_ptr_next   = (ring_ptr_reg == PTR_LAST) ? '0 : ring_ptr_reg + 1'b1;
                src_next        = ldmc_pkg::SRC_POT;
            end
            ldmc_pkg::MODE_ON: begin
                dval_next = MAX_DUTY_V;
            end
            ldmc_pkg::MODE_OFF: begin
                dval_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= ldmc_pkg::MODE_OFF;
            level_reg      <= '0;
            ring_ptr_reg   <= '0;
            ring_total_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++) begin
                knob_ring_reg[i] <= '0;
            end
        end else if (in_xfer) begin
            mode_reg       <= mode_next;
            level_reg      <= level_next;
            ring_ptr_reg   <= ring_ptr_next;
            ring_total_reg <= ring_total_next;
            if (ring_wr) begin
                knob_ring_reg[ring_ptr_reg] <= in_knob;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pot mapping pipeline: average, scale, divide
    // ------------------------------------------------------------------
    logic                v1_reg, v2_reg, v3_reg;
    ldmc_pkg::duty_src_t src1_reg, src2_reg, src3_reg;
    ldmc_pkg::mode_t     mode1_reg, mode2_reg, mode3_reg;
    logic [DUTY_W-1:0]   dval1_reg, dval2_reg, dval3_reg;
    logic [TOT_W-1:0]    total1_reg;
    logic [AVG_W-1:0]    avg2_reg;
    logic [PROD_W-1:0]   prod3_reg;

    logic [2*TOT_W:0]    avg_full;
    logic [2*PROD_W:0]   quot_full;
    logic [Q_W-1:0]      quot;
    logic [DUTY_W-1:0]   pot_duty;
    logic [DUTY_W-1:0]   duty_next;
    logic [DUTY_W-1:0]   m_duty_reg;
    ldmc_pkg::mode_t     m_mode_reg;

    assign avg_full  = (2*TOT_W+1)'(total1_reg) * (2*TOT_W+1)'(M1);
    assign quot_full = (2*PROD_W+1)'(prod3_reg) * (2*PROD_W+1)'(M2);
    assign quot      = quot_full[S2 +: Q_W];
    assign pot_duty  = (quot > Q_W'(MAX_DUTY)) ? MAX_DUTY_V : quot[DUTY_W-1:0];

    // Duty resolution into the result register
    always_comb begin
        unique case (src3_reg)
            ldmc_pkg::SRC_POT:  duty_next = pot_duty;
            ldmc_pkg::SRC_HOLD: duty_next = m_duty_reg;
            default:            duty_next = dval3_reg;
        endcase
    end

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg      <= in_xfer;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            src1_reg   <= src_next;
            mode1_reg  <= mode_next;
            dval1_reg  <= dval_next;
            total1_reg <= ring_total_next;

            src2_reg   <= src1_reg;
            mode2_reg  <= mode1_reg;
            dval2_reg  <= dval1_reg;
            avg2_reg   <= avg_full[S1 +: AVG_W];

            src3_reg   <= src2_reg;
            mode3_reg  <= mode2_reg;
            dval3_reg  <= dval2_reg;
            prod3_reg  <= PROD_W'(avg2_reg) * PROD_W'(MAX_DUTY_V);
        end
    end

    // Result register; duty keeps the last value for deadband holds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_duty_reg <= '0;
            m_mode_reg <= ldmc_pkg::MODE_OFF;
        end else if (pipe_en && v3_reg) begin
            m_duty_reg <= duty_next;
            m_mode_reg <= mode3_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_mode_reg, m_duty_reg};

`ifndef SYNTHESIS
    // Ring pointer never leaves the window
    ptr_in_window_a: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_ptr_reg <= PTR_LAST)
        else $error("knob ring pointer beyond window");

    // A finished item in the last stage reaches the result register
    stage_to_out_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && v3_reg) |=> m_tvalid)
        else $error("last stage item lost");

    // Fixed modes drive their fixed duty
    fixed_mode_duty_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_mode_reg == ldmc_pkg::MODE_OFF && m_duty_reg == '0)
                   || (m_mode_reg == ldmc_pkg::MODE_ON && m_duty_reg == MAX_DUTY_V)
                   || m_mode_reg == ldmc_pkg::MODE_SENSOR
                   || m_mode_reg == ldmc_pkg::MODE_POT))
        else $error("fixed mode with wrong duty");

    // Duty stays within range
    duty_range_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_duty_reg <= MAX_DUTY_V)
        else $error("duty above maximum");
`endif

endmodule

### test/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - lamp dimmer mode controller testbench
// Drives control ticks into the input stream and predicts duty and active
// mode for each tick. Covers radio and button priority, sensor deadband
// edges, pot window averaging and register writes, then runs random ticks
// under several settings with random idling and a long receiver stall.
// ============================================================================
module tb;

    localparam int LAMP_MAX_DUTY = ldmc_pkg::MAX_DUTY_DEF;
    localparam int KNOB_FULL     = ldmc_pkg::SAMPLE_MAX_DEF;
    localparam int KNOB_WINDOW   = ldmc_pkg::WINDOW_LEN_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_TICKS   = 195;

    // Register index past the end of the register file
    localparam logic [ldmc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Button patterns, bit 0 is the sensor button
    localparam logic [3:0] BTN_NONE   = 4'b0000;
    localparam logic [3:0] BTN_SENSOR = 4'b0001;
    localparam logic [3:0] BTN_POT    = 4'b0010;
    localparam logic [3:0] BTN_ON     = 4'b0100;
    localparam logic [3:0] BTN_OFF    = 4'b1000;
    localparam logic [3:0] BTN_ALL    = 4'b1111;

    // One control tick, last field first so it packs from bit 0 up
    typedef struct packed {
        logic [ldmc_pkg::RADIO_W-1:0]  radio_byte;
        logic                          radio_valid;
        logic [ldmc_pkg::SAMPLE_W-1:0] knob;
        logic [ldmc_pkg::SAMPLE_W-1:0] light;
        logic                          btn_off;
        logic                          btn_on;
        logic                          btn_pot;
        logic                          btn_sensor;
    } tick_t;

    typedef struct {
        logic [ldmc_pkg::DUTY_W-1:0] duty;
        ldmc_pkg::mode_t             mode;
    } lamp_result_t;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [ldmc_pkg::S_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [ldmc_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [ldmc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [ldmc_pkg::CFG_DATA_W-1:0] cfg_data;

    // Lamp state as the block should hold it
    ldmc_pkg::mode_t lamp_mode = ldmc_pkg::MODE_OFF;
    int    sensor_level   = 0;
    int    lamp_duty      = 0;
    int    knob_hist[KNOB_WINDOW];
    int    knob_pos       = 0;
    int    knob_sum       = 0;
    int    step_size_cfg  = int'(ldmc_pkg::STEP_SIZE_RST);
    int    setpoint_cfg   = int'(ldmc_pkg::SETPOINT_RST);
    int    deadband_cfg   = int'(ldmc_pkg::DEADBAND_RST);

    lamp_result_t duty_expect_q[$];

    int error_count  = 0;
    int stall_cycles = 0;
    int tx_idle_pct  = 35;
    int rx_idle_pct  = 35;
    int rx_hold_len  = 0;
    int last_knob    = 0;

    lamp_dimmer_mode_controller_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Lamp model: mode select, then the duty update of the active mode
    // ------------------------------------------------------------------
    function automatic void predict_tick(input tick_t t);
        int lo_edge;
        int hi_edge;
        int knob_avg;
        int mapped;
        lamp_result_t res;
        lo_edge = setpoint_cfg - deadband_cfg;
        hi_edge = setpoint_cfg + deadband_cfg;

        if (t.radio_valid && t.radio_byte == ldmc_pkg::RADIO_ON_CODE)
            lamp_mode = ldmc_pkg::MODE_ON;
        if (t.btn_sensor)
            lamp_mode = ldmc_pkg::MODE_SENSOR;
        else if (t.btn_pot)
            lamp_mode = ldmc_pkg::MODE_POT;
        else if (t.btn_on)
            lamp_mode = ldmc_pkg::MODE_ON;
        else if (t.btn_off)
            lamp_mode = ldmc_pkg::MODE_OFF;

        case (lamp_mode)
            ldmc_pkg::MODE_SENSOR: begin
                // inside the band both level and duty hold
                if (int'(t.light) < lo_edge) begin
                    sensor_level = sensor_level + step_size_cfg;
                    if (sensor_level > LAMP_MAX_DUTY)
                        sensor_level = LAMP_MAX_DUTY;
                    lamp_duty = sensor_level;
                end else if (int'(t.light) > hi_edge) begin
                    if (sensor_level > step_size_cfg)
                        sensor_level = sensor_level - step_size_cfg;
                    else
                        sensor_level = 0;
                    lamp_duty = sensor_level;
                end
            end
            ldmc_pkg::MODE_POT: begin
                knob_sum = knob_sum - knob_hist[knob_pos] + int'(t.knob);
                knob_hist[knob_pos] = int'(t.knob);
                knob_pos = (knob_pos + 1) % KNOB_WINDOW;
                knob_avg = knob_sum / KNOB_WINDOW;
                mapped = (knob_avg * LAMP_MAX_DUTY) / KNOB_FULL;
                lamp_duty = (mapped > LAMP_MAX_DUTY) ? LAMP_MAX_DUTY : mapped;
            end
            ldmc_pkg::MODE_ON:  lamp_duty = LAMP_MAX_DUTY;
            default:            lamp_duty = 0;
        endcase

        res.duty = lamp_duty[ldmc_pkg::DUTY_W-1:0];
        res.mode = lamp_mode;
        duty_expect_q.push_back(res);
    endfunction

    function automatic tick_t make_tick(input logic [3:0] buttons, input int light,
                                        input int knob, input logic radio_valid,
                                        input logic [ldmc_pkg::RADIO_W-1:0] radio_byte);
        tick_t t;
        t.btn_sensor  = buttons[0];
        t.btn_pot     = buttons[1];
        t.btn_on      = buttons[2];
        t.btn_off     = buttons[3];
        t.light       = light[ldmc_pkg::SAMPLE_W-1:0];
        t.knob        = knob[ldmc_pkg::SAMPLE_W-1:0];
        t.radio_valid = radio_valid;
        t.radio_byte  = radio_byte;
        return t;
    endfunction

    // Mostly button-free ticks so each mode runs for a while
    function automatic tick_t random_tick();
        logic [3:0] buttons;
        int light;
        int pick;
        int roll;
        logic [ldmc_pkg::RADIO_W-1:0] rbyte;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            buttons = 4'b0001 << $urandom_range(0, 3);
        else if (roll < 8)
            buttons = 4'($urandom_range(0, 15));
        else
            buttons = BTN_NONE;

        // light: band edges, rail values or anything
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            pick = $urandom_range(0, 3);
            if (pick < 2)
                light = setpoint_cfg - deadband_cfg - 1 + pick;
            else
                light = setpoint_cfg + deadband_cfg + pick - 2;
            if (light < 0 || light > KNOB_FULL)
                light = $urandom_range(0, KNOB_FULL);
        end else if (roll < 70) begin
            light = $urandom_range(0, 1) ? KNOB_FULL : 0;
        end else begin
            light = $urandom_range(0, KNOB_FULL);
        end

        // knob: sticky so the window can fill with one value
        roll = $urandom_range(0, 99);
        if (roll < 20)
            last_knob = $urandom_range(0, 1) ? KNOB_FULL : 0;
        else if (roll >= 50)
            last_knob = $urandom_range(0, KNOB_FULL);

        rbyte = ($urandom_range(0, 3) == 0) ? ldmc_pkg::RADIO_ON_CODE
                                            : 8'($urandom_range(0, 255));
        return make_tick(buttons, light, last_knob, $urandom_range(0, 99) < 10, rbyte);
    endfunction

    // ------------------------------------------------------------------
    // Input side: optional idle gap, then hold the tick until the transfer
    // ------------------------------------------------------------------
    task automatic send_tick(input tick_t t);
        int gap;
        gap = 0;
        while (gap < 6 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, t};
        do @(posedge aclk); while (!s_tready);
        predict_tick(t);
    endtask

    // Stop offering ticks and wait for every outstanding result
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (duty_expect_q.size() != 0);
    endtask

    task automatic cfg_write(input logic [ldmc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ldmc_pkg::CFG_DATA_W-1:0] data,
                             input bit keep_valid);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            ldmc_pkg::CFG_STEP_SIZE: step_size_cfg = int'(data[ldmc_pkg::STEP_W-1:0]);
            ldmc_pkg::CFG_SETPOINT:  setpoint_cfg  = int'(data[ldmc_pkg::SETPOINT_W-1:0]);
            ldmc_pkg::CFG_DEADBAND:  deadband_cfg  = int'(data[ldmc_pkg::DEADBAND_W-1:0]);
            default: ;
        endcase
        if (!keep_valid)
            cfg_valid <= 1'b0;
    endtask

    task automatic program_regs(input int step_v, input int setp_v, input int band_v);
        cfg_write(ldmc_pkg::CFG_STEP_SIZE, step_v[ldmc_pkg::CFG_DATA_W-1:0], 1'b1);
        cfg_write(ldmc_pkg::CFG_SETPOINT, setp_v[ldmc_pkg::CFG_DATA_W-1:0], 1'b1);
        cfg_write(ldmc_pkg::CFG_DEADBAND, band_v[ldmc_pkg::CFG_DATA_W-1:0], 1'b0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset state, radio code qualification, sensor entry inside the band
    task automatic test_idle_and_radio();
        send_tick(make_tick(BTN_NONE, 0, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, KNOB_FULL, KNOB_FULL, 1'b1, 8'h62));
        send_tick(make_tick(BTN_NONE, 0, 0, 1'b0, ldmc_pkg::RADIO_ON_CODE));
        send_tick(make_tick(BTN_NONE, 0, 0, 1'b1, ldmc_pkg::RADIO_ON_CODE));
        // in band: duty keeps the full-on value
        send_tick(make_tick(BTN_SENSOR, 2000, 0, 1'b0, 8'hFF));
        send_tick(make_tick(BTN_NONE, 0, 0, 1'b1, ldmc_pkg::RADIO_ON_CODE));
    endtask

    // Fixed priority sensor > pot > on > off; sensor, pot and off also over the radio
    task automatic test_button_priority();
        send_tick(make_tick(BTN_ALL, KNOB_FULL, KNOB_FULL, 1'b1,
                            ldmc_pkg::RADIO_ON_CODE));
        send_tick(make_tick(BTN_POT | BTN_ON | BTN_OFF, 0, KNOB_FULL, 1'b1,
                            ldmc_pkg::RADIO_ON_CODE));
        send_tick(make_tick(BTN_ON | BTN_OFF, 0, KNOB_FULL, 1'b0, 8'h00));
        send_tick(make_tick(BTN_OFF, 0, 0, 1'b1, ldmc_pkg::RADIO_ON_CODE));
        send_tick(make_tick(BTN_SENSOR | BTN_OFF, 0, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_POT, 0, KNOB_FULL, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, KNOB_FULL, KNOB_FULL, 1'b0, 8'h00));
    endtask

    // Deadband edges, including band limits past 0 and past full scale
    task automatic test_sensor_band();
        wait_results_drained();
        program_regs(25, 100, 2047);
        send_tick(make_tick(BTN_SENSOR, 0, 0, 1'b0, 8'h00));
        wait_results_drained();
        program_regs(25, 4095, 2047);
        send_tick(make_tick(BTN_SENSOR, 2047, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, 2048, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, KNOB_FULL, 0, 1'b0, 8'h00));
        wait_results_drained();
        program_regs(int'(ldmc_pkg::STEP_SIZE_RST), int'(ldmc_pkg::SETPOINT_RST),
                     int'(ldmc_pkg::DEADBAND_RST));
        send_tick(make_tick(BTN_SENSOR, 1899, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, 1900, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, 2100, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, 2101, 0, 1'b0, 8'h00));
    endtask

    // A write past the register file must leave every register alone
    task automatic test_unused_register();
        wait_results_drained();
        cfg_write(CFG_UNUSED, 12'hFFF, 1'b0);
        send_tick(make_tick(BTN_SENSOR, 1899, 0, 1'b0, 8'h00));
        send_tick(make_tick(BTN_NONE, 2101, 0, 1'b0, 8'h00));
    endtask

    // Receiver stalls for a long stretch while ticks keep coming
    task automatic test_backpressure();
        int n;
        tx_idle_pct = 0;
        rx_hold_len = 300;
        for (n = 0; n < 60; n++)
            send_tick(random_tick());
        tx_idle_pct = 35;
    endtask

    // Random ticks under a series of register settings
    task automatic test_random_settings();
        int step_tab[6] = '{10, 4095, 0, 1, -1, 1023};
        int setp_tab[6] = '{2000, 4095, 0, 2048, -1, 0};
        int band_tab[6] = '{100, 4095, 0, 1, -1, 2047};
        int ph;
        int n;
        for (ph = 0; ph < 6; ph++) begin
            wait_results_drained();
            // negative entries pick a random value
            program_regs(step_tab[ph] < 0 ? $urandom_range(0, 4095) : step_tab[ph],
                         setp_tab[ph] < 0 ? $urandom_range(0, 4095) : setp_tab[ph],
                         band_tab[ph] < 0 ? $urandom_range(0, 4095) : band_tab[ph]);
            // one phase runs with no idling at either side
            tx_idle_pct = (ph == 3) ? 0 : 35;
            rx_idle_pct = (ph == 3) ? 0 : 35;
            for (n = 0; n < PHASE_TICKS; n++)
                send_tick(random_tick());
        end
        tx_idle_pct = 35;
        rx_idle_pct = 35;
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready, long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_len > 0) begin
                hold_left   = rx_hold_len;
                rx_hold_len = 0;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge aclk) begin
        lamp_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (duty_expect_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got duty %0d mode %0d",
                         $time, m_tdata[ldmc_pkg::DUTY_W-1:0],
                         m_tdata[ldmc_pkg::M_DATA_W-1:ldmc_pkg::DUTY_W]);
                error_count++;
            end else begin
                want = duty_expect_q.pop_front();
                if (m_tdata[ldmc_pkg::DUTY_W-1:0] !== want.duty) begin
                    $display("%0t: duty mismatch, expected %0d, got %0d",
                             $time, want.duty, m_tdata[ldmc_pkg::DUTY_W-1:0]);
                    error_count++;
                end
                if (m_tdata[ldmc_pkg::M_DATA_W-1:ldmc_pkg::DUTY_W] !== want.mode) begin
                    $display("%0t: active_mode mismatch, expected %0d, got %0d",
                             $time, want.mode,
                             m_tdata[ldmc_pkg::M_DATA_W-1:ldmc_pkg::DUTY_W]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, duty_expect_q.size());
            $display("lamp_dimmer_mode_controller_top regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (knob_hist[i])
            knob_hist[i] = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= ldmc_pkg::CFG_STEP_SIZE;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_idle_and_radio();
        test_button_priority();
        test_sensor_band();
        test_unused_register();
        test_backpressure();
        test_random_settings();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("lamp_dimmer_mode_controller_top regression: pass");
        else
            $display("lamp_dimmer_mode_controller_top regression: fail");
        $finish;
    end

endmodule

### sim.f
src/ldmc_pkg.sv
src/lamp_dimmer_mode_controller_top.sv
test/tb.sv
